// ===== sv/ncpc_pkg.sv =====
`timescale 1ns / 1ps

package ncpc_pkg;

	// Frame limits.
	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 4096;

	// Column index and row counter widths. The row counter also covers the two
	// drain rows past the end of the frame.
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT + 2);

	// Field widths of the configuration registers and the result.
	localparam int MODE_W    = 2;
	localparam int WID_W     = 12;
	localparam int HGT_W     = 13;
	localparam int OUT_ROW_W = 12;
	localparam int OUT_COL_W = 11;

	// Register map.
	localparam int REG_COUNT = 3;
	localparam int PADDR_W   = $clog2(4 * REG_COUNT);
	localparam int PDATA_W   = 32;

	localparam logic [WID_W-1:0] WIDTH_RESET  = WID_W'(640);
	localparam logic [HGT_W-1:0] HEIGHT_RESET = HGT_W'(480);

	// Class tables: two tables of two rows of nine words.
	localparam int TABLE_COLS  = 9;
	localparam int TABLE_SIZE  = 2 * TABLE_COLS;
	localparam int TABLE_WORDS = 2 * TABLE_SIZE;
	localparam int TBL_AW      = $clog2(TABLE_WORDS);

	// Queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QP_W        = $clog2(QUEUE_DEPTH);

	// Pixel value that counts as a set neighbour, and the raw code base.
	localparam logic [7:0] PIXEL_FULL       = 8'hFF;
	localparam logic [7:0] RAW_NONZERO_BASE = 8'd100;

	typedef enum logic [1:0] {
		CMD_PIXEL       = 2'd0,
		CMD_DRAIN       = 2'd1,
		CMD_TABLE_WRITE = 2'd2
	} cmd_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_RAW     = 2'd0,
		MODE_TABLE_A = 2'd1,
		MODE_TABLE_B = 2'd2
	} mode_t;

	typedef enum logic [PADDR_W-3:0] {
		REG_MODE   = 2'd0,
		REG_WIDTH  = 2'd1,
		REG_HEIGHT = 2'd2
	} reg_idx_t;

	// Effective configuration seen by the datapath.
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [WID_W-1:0]  frame_width;
		logic [HGT_W-1:0]  frame_height;
	} cfg_t;

	// One queue entry: either a classified pixel or a table write.
	typedef struct packed {
		logic                 is_write;
		logic [3:0]           count;
		logic                 nonzero;
		logic [OUT_ROW_W-1:0] row;
		logic [OUT_COL_W-1:0] col;
		logic                 done;
		logic                 tbl_number;
		logic                 tbl_row;
		logic [3:0]           tbl_entry;
		logic [7:0]           tbl_value;
	} q_item_t;

endpackage

// ===== sv/ncpc_if.sv =====
`timescale 1ns / 1ps

// Input item channel.
interface ncpc_feed_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [7:0] pixel_value;
	logic       table_number;
	logic       table_row;
	logic [3:0] table_entry;
	logic [7:0] table_value;

	modport source (
		output valid, command, pixel_value, table_number, table_row, table_entry,
		       table_value,
		input  ready
	);
	modport sink (
		input  valid, command, pixel_value, table_number, table_row, table_entry,
		       table_value,
		output ready
	);
endinterface

// Result channel.
interface ncpc_result_if;
	logic        valid;
	logic        ready;
	logic [7:0]  class_value;
	logic [11:0] out_row;
	logic [10:0] out_col;
	logic        frame_done;

	modport source (
		output valid, class_value, out_row, out_col, frame_done,
		input  ready
	);
	modport sink (
		input  valid, class_value, out_row, out_col, frame_done,
		output ready
	);
endinterface

// ===== sv/neighbour_count_pixel_classifier_unit.sv =====
`timescale 1ns / 1ps
// Path: a result reaches the output register by way of the stage_s1 register and the queue once
// the slot that completes its window is accepted; that slot comes frame_width + 1 slots after
// the pixel itself. Throughput: one item per cycle while the queue is not full, set by the
// line store, which takes one read and one write in every cycle, and by the window shift.
// Reset: arst_n clears position, window, queue and output valid and loads the register
// defaults; the line store and the class tables are not cleared and need no clearing pass.

module neighbour_count_pixel_classifier_unit
	import ncpc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	ncpc_feed_if.sink          feed,
	ncpc_result_if.source      result
);

	logic [MODE_W-1:0] mode_q;
	logic [WID_W-1:0]  width_q;
	logic [HGT_W-1:0]  height_q;
	logic              reg_wr;
	reg_idx_t          reg_idx;
	logic              restart;
	cfg_t              cfg;

	logic              push;
	q_item_t           push_item;
	logic              full;
	logic              pop;
	logic              head_valid;
	q_item_t           head_item;

	assign pready  = 1'b1;
	assign reg_wr  = psel && penable && pwrite;
	assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign restart = reg_wr && (reg_idx == REG_WIDTH || reg_idx == REG_HEIGHT);

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_RAW;
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (reg_wr) begin
			case (reg_idx)
				REG_MODE: begin
					mode_q <= pwdata[MODE_W-1:0];
				end
				REG_WIDTH: begin
					width_q <= pwdata[WID_W-1:0];
				end
				REG_HEIGHT: begin
					height_q <= pwdata[HGT_W-1:0];
				end
				default: begin
					mode_q <= mode_q;
				end
			endcase
		end
	end

	// Register reads.
	always_comb begin
		case (reg_idx)
			REG_MODE: begin
				prdata = PDATA_W'(mode_q);
			end
			REG_WIDTH: begin
				prdata = PDATA_W'(width_q);
			end
			REG_HEIGHT: begin
				prdata = PDATA_W'(height_q);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	// Frame size as used by the datapath: zero acts as one, large values saturate.
	always_comb begin
		cfg.mode = mode_q;
		if (width_q == '0) begin
			cfg.frame_width = WID_W'(1);
		end else if (width_q > WID_W'(MAX_WIDTH)) begin
			cfg.frame_width = WID_W'(MAX_WIDTH);
		end else begin
			cfg.frame_width = width_q;
		end
		if (height_q == '0) begin
			cfg.frame_height = HGT_W'(1);
		end else if (height_q > HGT_W'(MAX_HEIGHT)) begin
			cfg.frame_height = HGT_W'(MAX_HEIGHT);
		end else begin
			cfg.frame_height = height_q;
		end
	end

	ncpc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.restart   (restart),
		.feed      (feed),
		.push      (push),
		.push_item (push_item),
		.full      (full)
	);

	ncpc_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	ncpc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.mode       (cfg.mode),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop),
		.result     (result)
	);

endmodule

// ===== sv/ncpc_front.sv =====
`timescale 1ns / 1ps

module ncpc_front
	import ncpc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     restart,
	ncpc_feed_if.sink feed,
	output logic     push,
	output q_item_t  push_item,
	input  logic     full
);

	typedef struct packed {
		logic                 is_slot;
		logic [1:0]           flags;
		logic [COL_W-1:0]     col;
		logic                 has_out;
		logic [OUT_ROW_W-1:0] qrow;
		logic [OUT_COL_W-1:0] qcol;
		logic                 top_ok;
		logic                 bot_ok;
		logic                 done;
		logic                 byp_hit;
		logic                 tbl_number;
		logic                 tbl_row;
		logic [3:0]           tbl_entry;
		logic [7:0]           tbl_value;
	} s1_t;

	// Number of set cells in one window column, with rows masked at the frame edge.
	function automatic logic [3:0] col_count(logic [5:0] c, logic top_ok, logic mid_ok,
	                                         logic bot_ok);
		logic [3:0] n;
		n = {3'b000, top_ok & c[0]} + {3'b000, mid_ok & c[2]} + {3'b000, bot_ok & c[4]};
		return n;
	endfunction

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [3:0]       line_mem [MAX_WIDTH];
	logic [3:0]       line_rd_q;
	logic [3:0]       byp_q;
	logic [17:0]      window_q;
	logic             valid_s1;
	s1_t              stage_s1;

	logic             accept;
	logic             is_slot;
	logic             is_tw;
	logic             in_frame;
	logic             row_at_end;
	logic [COL_W-1:0] w_last;
	logic [ROW_W-1:0] h_row;
	logic [ROW_W-1:0] qrow_full;
	logic [1:0]       pix_flags;
	s1_t              s1_next;

	logic [3:0]       word;
	logic [5:0]       fresh;
	logic [5:0]       left;
	logic [5:0]       centre;
	logic [5:0]       right;
	logic [3:0]       count;
	logic             s1_adv;
	logic             s1_wr;

	assign accept     = feed.valid && feed.ready;
	assign w_last     = COL_W'(cfg.frame_width - WID_W'(1));
	assign h_row      = ROW_W'(cfg.frame_height);
	assign in_frame   = row_q < h_row;
	assign row_at_end = row_q == h_row + ROW_W'(1);

	// Decode the command: which items take a slot, which go to the table.
	always_comb begin
		is_slot = 1'b0;
		is_tw   = 1'b0;
		case (cmd_t'(feed.command))
			CMD_PIXEL: begin
				is_slot = 1'b1;
			end
			CMD_DRAIN: begin
				is_slot = !in_frame;
			end
			CMD_TABLE_WRITE: begin
				is_tw = feed.table_entry <= 4'(TABLE_COLS - 1);
			end
			default: begin
				is_slot = 1'b0;
			end
		endcase
	end

	// Pixel flags: bit 0 full, bit 1 nonzero. Past the frame the bottom row is empty.
	assign pix_flags = (cmd_t'(feed.command) == CMD_PIXEL && in_frame) ?
	                   {feed.pixel_value != 8'd0, feed.pixel_value == PIXEL_FULL} : 2'b00;

	// The window completed by this slot is centred one row and one column back in raster order.
	assign qrow_full = (col_q != '0) ? row_q - ROW_W'(1) : row_q - ROW_W'(2);

	always_comb begin
		s1_next            = '0;
		s1_next.is_slot    = is_slot;
		s1_next.flags      = pix_flags;
		s1_next.col        = col_q;
		s1_next.has_out    = !(row_q == '0 || (row_q == ROW_W'(1) && col_q == '0));
		s1_next.qrow       = OUT_ROW_W'(qrow_full);
		s1_next.qcol       = OUT_COL_W'((col_q != '0) ? col_q - COL_W'(1) : w_last);
		s1_next.top_ok     = qrow_full != '0;
		s1_next.bot_ok     = (qrow_full + ROW_W'(1)) < h_row;
		s1_next.done       = row_at_end;
		s1_next.byp_hit    = s1_wr && (stage_s1.col == col_q);
		s1_next.tbl_number = feed.table_number;
		s1_next.tbl_row    = feed.table_row;
		s1_next.tbl_entry  = feed.table_entry;
		s1_next.tbl_value  = feed.table_value;
	end

	// Raster position of the next slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept && is_slot) begin
			if (row_at_end) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_q == w_last) begin
				col_q <= '0;
				row_q <= row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// Line store: per column the flags of the two previous rows, {upper, middle}.
	always_ff @(posedge clk) begin
		if (s1_wr) begin
			line_mem[stage_s1.col] <= {word[1:0], stage_s1.flags};
		end
		if (accept && is_slot) begin
			line_rd_q <= line_mem[col_q];
		end
	end

	// The last written word covers a read of the same column in the same cycle.
	always_ff @(posedge clk) begin
		if (s1_wr) begin
			byp_q <= {word[1:0], stage_s1.flags};
		end
	end

	// Stage 1 register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (feed.ready) begin
			valid_s1 <= feed.valid && (is_slot || is_tw);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stage_s1 <= s1_next;
		end
	end

	// Build the new window column and count the full neighbours.
	assign word   = stage_s1.byp_hit ? byp_q : line_rd_q;
	assign fresh  = {stage_s1.flags, word[1:0], word[3:2]};
	assign left   = window_q[11:6];
	assign centre = window_q[17:12];
	assign right  = (stage_s1.col == '0) ? 6'd0 : fresh;
	assign count  = col_count(left, stage_s1.top_ok, 1'b1, stage_s1.bot_ok)
	              + col_count(centre, stage_s1.top_ok, 1'b0, stage_s1.bot_ok)
	              + col_count(right, stage_s1.top_ok, 1'b1, stage_s1.bot_ok);

	assign push   = valid_s1 && (!stage_s1.is_slot || stage_s1.has_out);
	assign s1_adv = valid_s1 && (!push || !full);
	assign s1_wr  = s1_adv && stage_s1.is_slot;

	assign feed.ready = !valid_s1 || s1_adv;

	// Three columns of flags; a new row starts with empty columns on the left.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (s1_wr) begin
			if (stage_s1.col == '0) begin
				window_q <= {fresh, 12'd0};
			end else begin
				window_q <= {fresh, window_q[17:12], window_q[11:6]};
			end
		end
	end

	always_comb begin
		push_item            = '0;
		push_item.is_write   = !stage_s1.is_slot;
		push_item.count      = count;
		push_item.nonzero    = centre[3];
		push_item.row        = stage_s1.qrow;
		push_item.col        = stage_s1.qcol;
		push_item.done       = stage_s1.done;
		push_item.tbl_number = stage_s1.tbl_number;
		push_item.tbl_row    = stage_s1.tbl_row;
		push_item.tbl_entry  = stage_s1.tbl_entry;
		push_item.tbl_value  = stage_s1.tbl_value;
	end

endmodule

// ===== sv/ncpc_fifo.sv =====
`timescale 1ns / 1ps

module ncpc_fifo
	import ncpc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  q_item_t push_item,
	output logic    full,
	input  logic    pop,
	output logic    head_valid,
	output q_item_t head_item
);

	q_item_t         mem_q [QUEUE_DEPTH];
	logic [QP_W-1:0] wr_ptr_q;
	logic [QP_W-1:0] rd_ptr_q;
	logic [QP_W:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full       = count_q == (QP_W + 1)'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_item  = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QP_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QP_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (QP_W + 1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (QP_W + 1)'(1);
			end
		end
	end

endmodule

// ===== sv/ncpc_back.sv =====
`timescale 1ns / 1ps

module ncpc_back
	import ncpc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [MODE_W-1:0] mode,
	input  logic              head_valid,
	input  q_item_t           head_item,
	output logic              pop,
	ncpc_result_if.source     result
);

	logic [7:0]        tbl_mem [TABLE_WORDS];
	logic [7:0]        tbl_rd_q;
	q_item_t           res_q;
	logic              res_valid_q;
	logic              out_free;
	logic              take_result;
	logic [TBL_AW-1:0] wr_addr;
	logic [TBL_AW-1:0] rd_addr;
	logic [7:0]        raw_code;

	assign out_free    = !res_valid_q || result.ready;
	assign pop         = head_valid && (head_item.is_write || out_free);
	assign take_result = pop && !head_item.is_write;

	// Table word addresses: table, then centre row, then neighbour count.
	assign wr_addr = TBL_AW'(head_item.tbl_number ? TABLE_SIZE : 0)
	               + TBL_AW'(head_item.tbl_row ? TABLE_COLS : 0)
	               + TBL_AW'(head_item.tbl_entry);
	assign rd_addr = TBL_AW'((mode_t'(mode) == MODE_TABLE_B) ? TABLE_SIZE : 0)
	               + TBL_AW'(head_item.nonzero ? TABLE_COLS : 0)
	               + TBL_AW'(head_item.count);

	// Class tables.
	always_ff @(posedge clk) begin
		if (pop && head_item.is_write) begin
			tbl_mem[wr_addr] <= head_item.tbl_value;
		end
		if (take_result) begin
			tbl_rd_q <= tbl_mem[rd_addr];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= take_result;
		end
	end

	always_ff @(posedge clk) begin
		if (take_result) begin
			res_q <= head_item;
		end
	end

	// Select the class byte for the configured mode.
	assign raw_code = res_q.nonzero ? RAW_NONZERO_BASE + {4'd0, res_q.count}
	                                : {4'd0, res_q.count};

	always_comb begin
		case (mode_t'(mode))
			MODE_RAW: begin
				result.class_value = raw_code;
			end
			MODE_TABLE_A, MODE_TABLE_B: begin
				result.class_value = tbl_rd_q;
			end
			default: begin
				result.class_value = 8'd0;
			end
		endcase
	end

	assign result.valid      = res_valid_q;
	assign result.out_row    = res_q.row;
	assign result.out_col    = res_q.col;
	assign result.frame_done = res_q.done;

endmodule

// ===== sv/ncpc_checker.sv =====
`timescale 1ns / 1ps

module ncpc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  class_value,
	input logic [11:0] out_row,
	input logic [10:0] out_col,
	input logic        frame_done
);

	logic        out_fire;
	logic        have_prev_q;
	logic        prev_done_q;
	logic [11:0] prev_row_q;
	logic [10:0] prev_col_q;

	assign out_fire = out_valid && out_ready;

	// Position of the last delivered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
			prev_done_q <= 1'b0;
			prev_row_q  <= '0;
			prev_col_q  <= '0;
		end else if (out_fire) begin
			have_prev_q <= 1'b1;
			prev_done_q <= frame_done;
			prev_row_q  <= out_row;
			prev_col_q  <= out_col;
		end
	end

	// A pending result stays offered until taken.
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result transaction withdrawn before it was taken");

	// A pending result keeps its payload.
	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(class_value) && $stable(out_row) &&
		$stable(out_col) && $stable(frame_done))
		else $error("result payload changed while stalled");

	// Results of a frame come in raster order (a size write restarts at the origin).
	a_raster_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && have_prev_q && !prev_done_q |->
		(out_row == prev_row_q && out_col == prev_col_q + 11'd1) ||
		(out_col == 11'd0 && out_row == prev_row_q + 12'd1) ||
		(out_col == 11'd0 && out_row == 12'd0))
		else $error("result out of raster order");

	// After the last pixel of a frame the next result is the first of a frame.
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && have_prev_q && prev_done_q |-> out_row == 12'd0 && out_col == 11'd0)
		else $error("new frame does not start at the origin");

	// No result is offered while reset is held.
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result offered during reset");

endmodule

bind neighbour_count_pixel_classifier_unit ncpc_checker u_ncpc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.class_value (result.class_value),
	.out_row     (result.out_row),
	.out_col     (result.out_col),
	.frame_done  (result.frame_done)
);
